// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

// ----- src/twp_pkg.sv -----
package twp_pkg;

	localparam int WEIGHT_WIDTH   = 16;
	// Block size must be a power of two; block ends are found from the low column bits.
	localparam int BLOCK_SIZE     = 256;
	localparam int BLOCK_LOG      = $clog2(BLOCK_SIZE);
	localparam int CODES_PER_WORD = 16;
	localparam int CODE_W         = 2;
	localparam int WORD_W         = CODES_PER_WORD * CODE_W;
	localparam int SLOT_W         = $clog2(CODES_PER_WORD);
	localparam int SCALE_W        = 16;
	localparam int COL_W          = 17;
	localparam int SUM_W          = 24;
	localparam int CNT_W          = 9;
	localparam int BLK_W          = 9;
	localparam int IN_TDATA_W     = ((WEIGHT_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W    = ((WORD_W + SCALE_W + 7) / 8) * 8;
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_DATA_W     = 17;
	localparam int QDEPTH         = 4;
	localparam int QPTR_W         = $clog2(QDEPTH);

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [BLK_W-1:0] BLK_MAX = {BLK_W{1'b1}};

	localparam logic [COL_W-1:0] ROW_LENGTH_RESET     = COL_W'(256);
	localparam logic [BLK_W-1:0] BLOCKS_PER_ROW_RESET = BLK_W'(1);

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_ROW = CFG_IDX_W'(1);

	localparam logic [CODE_W-1:0] CODE_ZERO = 2'h0;
	localparam logic [CODE_W-1:0] CODE_POS  = 2'h1;
	localparam logic [CODE_W-1:0] CODE_NEG  = 2'h2;

	localparam logic KIND_WORD  = 1'b0;
	localparam logic KIND_SCALE = 1'b1;

	typedef struct packed {
		logic              has_word;
		logic [WORD_W-1:0] word;
		logic              has_scale;
		logic [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]  count;
	} twp_job_t;

endpackage

// ----- src/ternary_weight_packer.sv -----
// Path: a packed word is written to the job queue, then loaded into the output register;
// a block scale follows once the 24-step divider is done and the output is free.
// Throughput: one weight beat per cycle while the four-entry job queue has room; each
// scale holds the back end until it is loaded out, so very short blocks or rows slow input.
// Reset: counters and queue clear, row_length returns to 256 and blocks_per_row to 1.
module ternary_weight_packer
	import twp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // weight
	input  logic                   s_tlast,   // last_in_matrix
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // packed_word, scale_value
	output logic                   m_tuser,   // kind
	output logic                   m_tlast,   // last
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	twp_job_t           push_job;
	twp_job_t           head;
	logic               push;
	logic               pop;
	logic               empty;
	logic               full;
	logic [WORD_W-1:0]  out_word;
	logic [SCALE_W-1:0] out_scale;

	assign s_tready  = !full;
	assign cfg_ready = 1'b1;

	twp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.weight         (s_tdata[WEIGHT_WIDTH-1:0]),
		.last_in_matrix (s_tlast),
		.cfg_write      (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.job            (push_job)
	);

	twp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	twp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_word  (out_word),
		.out_scale (out_scale),
		.out_last  (m_tlast)
	);

	assign m_tdata = OUT_TDATA_W'({out_scale, out_word});

endmodule

// ----- src/twp_front.sv -----
module twp_front
	import twp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [WEIGHT_WIDTH-1:0] weight,
	input  logic                    last_in_matrix,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    push,
	output twp_job_t                job
);

	localparam int SUM_EXT_W = ((WEIGHT_WIDTH > SUM_W) ? WEIGHT_WIDTH : SUM_W) + 1;

	logic [COL_W-1:0]  row_len_q;
	logic [BLK_W-1:0]  bpr_q;
	logic [COL_W-1:0]  col_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  nz_q;
	logic [WORD_W-1:0] acc_q;
	logic [SLOT_W-1:0] slot_q;
	logic [BLK_W-1:0]  blk_q;

	logic                    accept;
	logic                    neg;
	logic                    zero;
	logic [WEIGHT_WIDTH-1:0] mag;
	logic [CODE_W-1:0]       code;
	logic [COL_W:0]          next_col;
	logic                    row_end;
	logic                    block_end;
	logic                    word_end;
	logic                    scale_en;
	logic [SUM_EXT_W-1:0]    sum_ext;
	logic [SUM_W-1:0]        sum_n;
	logic [CNT_W-1:0]        nz_n;
	logic [WORD_W-1:0]       acc_n;

	assign accept = in_valid && in_ready;
	assign neg    = weight[WEIGHT_WIDTH-1];
	assign zero   = (weight == '0);
	// The most negative weight negates to itself, which read unsigned is its magnitude.
	assign mag    = neg ? (~weight + WEIGHT_WIDTH'(1)) : weight;
	assign code   = zero ? CODE_ZERO : (neg ? CODE_NEG : CODE_POS);

	assign next_col  = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_end   = last_in_matrix || (next_col >= {1'b0, row_len_q});
	assign block_end = row_end || (next_col[BLOCK_LOG-1:0] == '0);
	assign word_end  = row_end || (slot_q >= SLOT_W'(CODES_PER_WORD - 1));
	assign scale_en  = block_end && (blk_q < bpr_q);

	assign sum_ext = SUM_EXT_W'(sum_q) + SUM_EXT_W'(mag);
	assign sum_n   = (sum_ext > SUM_EXT_W'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
	assign nz_n    = (!zero && nz_q < CNT_MAX) ? nz_q + CNT_W'(1) : nz_q;
	assign acc_n   = acc_q | (WORD_W'(code) << {slot_q, 1'b0});

	assign push          = accept && (word_end || scale_en);
	assign job.has_word  = word_end;
	assign job.word      = acc_n;
	assign job.has_scale = scale_en;
	assign job.sum       = sum_n;
	assign job.count     = nz_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q <= ROW_LENGTH_RESET;
			bpr_q     <= BLOCKS_PER_ROW_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_ROW_LENGTH) begin
				row_len_q <= cfg_data[COL_W-1:0];
			end else if (cfg_index == CFG_BLOCKS_PER_ROW) begin
				bpr_q <= cfg_data[BLK_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			sum_q  <= '0;
			nz_q   <= '0;
			acc_q  <= '0;
			slot_q <= '0;
			blk_q  <= '0;
		end else if (accept) begin
			if (word_end) begin
				acc_q  <= '0;
				slot_q <= '0;
			end else begin
				acc_q  <= acc_n;
				slot_q <= slot_q + SLOT_W'(1);
			end
			if (block_end) begin
				sum_q <= '0;
				nz_q  <= '0;
				if (blk_q < BLK_MAX) begin
					blk_q <= blk_q + BLK_W'(1);
				end
			end else begin
				sum_q <= sum_n;
				nz_q  <= nz_n;
			end
			if (row_end) begin
				col_q <= '0;
				blk_q <= '0;
			end else begin
				col_q <= next_col[COL_W-1:0];
			end
		end
	end

endmodule

// ----- src/twp_queue.sv -----
`include "assert_macros.svh"

module twp_queue
	import twp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  twp_job_t push_job,
	input  logic     pop,
	output twp_job_t head,
	output logic     empty,
	output logic     full
);

	twp_job_t          entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	`ASSERT_IMPLIES(a_no_push_full, push, !full)
	`ASSERT_IMPLIES(a_no_pop_empty, pop, !empty)
	`ASSERT_ALWAYS(a_count_bound, count_q <= (QPTR_W+1)'(QDEPTH))
	`ASSERT_IMPLIES(a_ptr_gap, !full, (count_q[QPTR_W-1:0] == QPTR_W'(wr_q - rd_q)))

endmodule

// ----- src/twp_div.sv -----
module twp_div
	import twp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [CNT_W-1:0]   divisor,
	output logic               done,
	output logic [SCALE_W-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic              zero_q;

	logic [CNT_W:0] rem_sh;
	logic           ge;
	logic [CNT_W:0] rem_nx;

	// Restoring division, one quotient bit per cycle; quotient bits replace the dividend.
	assign rem_sh   = {rem_q, dvd_q[SUM_W-1]};
	assign ge       = (rem_sh >= {1'b0, dsr_q});
	assign rem_nx   = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	assign done     = done_q;
	assign quotient = zero_q ? '0 : dvd_q[SCALE_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= rem_nx[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

// ----- src/twp_back.sv -----
module twp_back
	import twp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  twp_job_t               head,
	input  logic                   empty,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_kind,
	output logic [WORD_W-1:0]      out_word,
	output logic [SCALE_W-1:0]     out_scale,
	output logic                   out_last
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic               state_q;
	logic               valid_q;
	logic               kind_q;
	logic [WORD_W-1:0]  word_q;
	logic [SCALE_W-1:0] scale_q;
	logic               last_q;

	logic               out_free;
	logic               div_start;
	logic               div_done;
	logic [SCALE_W-1:0] div_quot;
	logic               load_word;
	logic               load_scale;

	assign out_free   = !valid_q || out_ready;
	assign pop        = (state_q == ST_IDLE) && !empty && out_free;
	assign load_word  = pop && head.has_word;
	assign div_start  = pop && head.has_scale;
	assign load_scale = (state_q == ST_DIV) && div_done && out_free;

	twp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (head.sum),
		.divisor  (head.count),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (load_word || load_scale) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (load_scale) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_word) begin
			kind_q  <= KIND_WORD;
			word_q  <= head.word;
			scale_q <= '0;
			last_q  <= !head.has_scale;
		end else if (load_scale) begin
			kind_q  <= KIND_SCALE;
			word_q  <= '0;
			scale_q <= div_quot;
			last_q  <= 1'b1;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_word  = word_q;
	assign out_scale = scale_q;
	assign out_last  = last_q;

endmodule
